FILE: rtl/mmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmg_pkg: shared definitions for the min-max gray normaliser
// Widths, register map, request codes and reset values used by all modules.
// ----------------------------------------------------------------------------
package mmg_pkg;

    // Default build parameters of the top level.
    localparam int MAX_PIXELS_DEF  = 16384;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fraction bits of the fixed-point sample; 1.0 is 1 << FRAC_BITS.
    localparam int FRAC_BITS = 8;

    // Gray output.
    localparam int              GRAY_W   = 8;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;
    localparam logic [GRAY_W-1:0] GRAY_MIN = 8'd0;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_COUNT = 1'b0;

    // Pixel count register.
    localparam int                        PIXEL_COUNT_W     = 15;
    localparam logic [PIXEL_COUNT_W-1:0]  PIXEL_COUNT_RESET = 15'd16384;

endpackage : mmg_pkg
`default_nettype wire

FILE: rtl/mmg_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmg_cfg_regs: configuration register bank
// Holds the pixel count register behind the APB-style port and derives the
// effective frame size, limited to the range one to MAX_PIXELS.
// ----------------------------------------------------------------------------
module mmg_cfg_regs #(
    parameter int MAX_PIXELS = mmg_pkg::MAX_PIXELS_DEF,
    parameter int SIZE_W     = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mmg_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mmg_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [SIZE_W-1:0]             frame_size
);

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_PIXELS);
    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);

    logic [mmg_pkg::PIXEL_COUNT_W-1:0] pixel_count_reg;
    logic [mmg_pkg::PIXEL_COUNT_W-1:0] pixel_count_next;
    logic [mmg_pkg::REG_IDX_W-1:0]     reg_idx;
    logic [SIZE_W-1:0]                 pc_ext;

    assign pready  = 1'b1;
    assign reg_idx = paddr[mmg_pkg::PADDR_W-1:2];

    always_comb
    begin
        pixel_count_next = pixel_count_reg;
        if (psel && penable && pwrite && (reg_idx == mmg_pkg::REG_PIXEL_COUNT))
        begin
            pixel_count_next = pwdata[mmg_pkg::PIXEL_COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= mmg_pkg::PIXEL_COUNT_RESET;
        end
        else
        begin
            pixel_count_reg <= pixel_count_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == mmg_pkg::REG_PIXEL_COUNT)
        begin
            prdata = mmg_pkg::PDATA_W'(pixel_count_reg);
        end
    end

    // A count of zero behaves as one pixel; anything above the store size
    // is held to the store size.
    always_comb
    begin
        pc_ext = SIZE_W'(pixel_count_reg);
        if (pc_ext == '0)
        begin
            frame_size = SIZE_ONE;
        end
        else if (pc_ext > SIZE_MAX)
        begin
            frame_size = SIZE_MAX;
        end
        else
        begin
            frame_size = pc_ext;
        end
    end

endmodule : mmg_cfg_regs
`default_nettype wire

FILE: rtl/mmg_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmg_frame_store: sample memory
// Single write port and single registered read port holding one frame.
// ----------------------------------------------------------------------------
module mmg_frame_store #(
    parameter int DEPTH  = mmg_pkg::MAX_PIXELS_DEF,
    parameter int WIDTH  = mmg_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W = 14
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : mmg_frame_store
`default_nettype wire

FILE: rtl/mmg_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmg_serial_div: bit-serial restoring divider
// Produces an 8-bit quotient, one bit per cycle, for a numerator known to
// be below 256 times the divisor. The low numerator bits shift in serially.
// ----------------------------------------------------------------------------
module mmg_serial_div #(
    parameter int DW = 18
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [DW+mmg_pkg::GRAY_W-1:0] num,
    input  wire logic [DW-1:0]                 den,
    output logic                               done,
    output logic      [mmg_pkg::GRAY_W-1:0]    quot
);

    localparam int GW = mmg_pkg::GRAY_W;
    localparam int CW = $clog2(GW);
    localparam logic [CW-1:0] LAST_STEP = CW'(GW - 1);

    logic          busy_reg,  busy_next;
    logic          done_reg,  done_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [DW-1:0] den_reg,   den_next;
    logic [DW-1:0] rem_reg,   rem_next;
    logic [GW-1:0] low_reg,   low_next;
    logic [GW-1:0] quot_reg,  quot_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One restoring step: bring down the next numerator bit and subtract
    // the divisor where it fits.
    assign trial = {rem_reg, low_reg[GW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            rem_next  = num[DW+GW-1:GW];
            low_next  = num[GW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
            low_next  = {low_reg[GW-2:0], 1'b0};
            quot_next = {quot_reg[GW-2:0], ge};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule : mmg_serial_div
`default_nettype wire

FILE: rtl/minmax_normalize_to_gray.sv
`default_nettype none
// ----------------------------------------------------------------------------
// minmax_normalize_to_gray: min-max contrast stretch to 8-bit gray
// Loads a frame of signed fixed-point samples while tracking minimum and
// maximum, then answers fetch requests with the stretched gray level.
// ----------------------------------------------------------------------------
// A load request is taken in the idle state and needs no further step. A fetch of a
// loaded frame goes through set-up on the read sample, eight quotient bits, quotient
// capture and hand-over; a clamped pixel skips the division, an early fetch the set-up.
// One request at a time: further requests stall until a fetch's result is handed over,
// a division running on the one-bit-per-cycle restoring divider. Reset (rst_n, async,
// active low) clears counts, restores min and max, sets pixel_count to 16384; no store clear.
// ----------------------------------------------------------------------------
module minmax_normalize_to_gray #(
    parameter int MAX_PIXELS  = mmg_pkg::MAX_PIXELS_DEF,
    parameter int SAMPLE_BITS = mmg_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          req_type,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mmg_pkg::GRAY_W-1:0]    gray,
    output logic                               last_pixel,
    output logic                               not_ready,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mmg_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mmg_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    // Widths. The count must reach the store depth itself; the frame size
    // is wide enough to hold both the count and the register value.
    localparam int SW     = SAMPLE_BITS;
    localparam int GW     = mmg_pkg::GRAY_W;
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int SIZE_W = (CNT_W > mmg_pkg::PIXEL_COUNT_W) ? CNT_W
                                                             : mmg_pkg::PIXEL_COUNT_W;
    // Extended width for the stretch arithmetic: holds differences of two
    // samples and the value 1.0 used for a flat frame.
    localparam int EW     = SW + 2;

    localparam logic signed [SW-1:0] SAMPLE_POS_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_NEG_MAX = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [EW-1:0] ONE_POINT_ZERO = EW'(1) <<< mmg_pkg::FRAC_BITS;

    // Sequencer codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;

    logic [2:0]              state_reg,   state_next;
    logic [CNT_W-1:0]        loaded_reg,  loaded_next;
    logic [ADDR_W-1:0]       rdpos_reg,   rdpos_next;
    logic signed [SW-1:0]    min_reg,     min_next;
    logic signed [SW-1:0]    max_reg,     max_next;
    logic [GW-1:0]           res_gray_reg, res_gray_next;
    logic                    res_last_reg, res_last_next;
    logic                    res_nr_reg,   res_nr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [GW-1:0]           gray_reg;
    logic                    last_reg;
    logic                    nr_reg;

    logic [SIZE_W-1:0]       frame_size;
    logic                    accept;
    logic                    frame_full;
    logic                    fetch_last;
    logic                    out_free;

    logic                    mem_wr_en;
    logic                    mem_rd_en;
    logic [SW-1:0]           mem_rd_data;

    logic signed [EW-1:0]    v_e;
    logic signed [EW-1:0]    lo_e;
    logic signed [EW-1:0]    hi_e;
    logic signed [EW-1:0]    lo_sel;
    logic signed [EW-1:0]    hi_sel;
    logic signed [EW-1:0]    diff_v;
    logic signed [EW-1:0]    diff_span;
    logic [EW+GW-1:0]        div_num;
    logic                    div_start;
    logic                    div_done;
    logic [GW-1:0]           div_quot;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    mmg_cfg_regs #(
        .MAX_PIXELS (MAX_PIXELS),
        .SIZE_W     (SIZE_W)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_size (frame_size)
    );

    // ------------------------------------------------------------------
    // Frame store. A load writes at the fill count; a fetch reads at the
    // read position, with the data ready in the set-up cycle.
    // ------------------------------------------------------------------
    mmg_frame_store #(
        .DEPTH   (MAX_PIXELS),
        .WIDTH   (SW),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (loaded_reg[ADDR_W-1:0]),
        .wr_data (sample),
        .rd_en   (mem_rd_en),
        .rd_addr (rdpos_reg),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Serial divider for the stretch quotient
    // ------------------------------------------------------------------
    mmg_serial_div #(
        .DW    (EW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (diff_span),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Requests are taken only while the sequencer is idle; the result
    // register lets the next request in while a result waits downstream.
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    // The frame counts as full once the fill count reaches the current
    // frame size. The last pixel is the one at or past the final position.
    assign frame_full = (SIZE_W'(loaded_reg) >= frame_size);
    assign fetch_last = ((SIZE_W'(rdpos_reg) + SIZE_W'(1)) >= frame_size);

    assign mem_wr_en  = accept && (req_type == mmg_pkg::REQ_LOAD) && !frame_full;
    assign mem_rd_en  = accept && (req_type == mmg_pkg::REQ_FETCH) && frame_full;

    // Stretch set-up. A flat frame (max not above min) stretches the range
    // zero to one instead. The scaled numerator is 255 times the offset,
    // formed as 256 times the offset less the offset.
    assign v_e       = EW'(signed'(mem_rd_data));
    assign lo_e      = EW'(min_reg);
    assign hi_e      = EW'(max_reg);
    assign lo_sel    = (hi_e <= lo_e) ? '0 : lo_e;
    assign hi_sel    = (hi_e <= lo_e) ? ONE_POINT_ZERO : hi_e;
    assign diff_v    = v_e - lo_sel;
    assign diff_span = hi_sel - lo_sel;
    assign div_num   = {unsigned'(diff_v), {GW{1'b0}}}
                     - {{GW{1'b0}}, unsigned'(diff_v)};
    assign div_start = (state_reg == S_PREP) && (v_e > lo_sel) && (v_e < hi_sel);

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        rdpos_next     = rdpos_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        res_gray_next  = res_gray_reg;
        res_last_next  = res_last_reg;
        res_nr_next    = res_nr_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == mmg_pkg::REQ_LOAD)
                    begin
                        // Loads into a full frame are dropped.
                        if (!frame_full)
                        begin
                            loaded_next = loaded_reg + CNT_W'(1);
                            if (sample < min_reg)
                            begin
                                min_next = sample;
                            end
                            if (sample > max_reg)
                            begin
                                max_next = sample;
                            end
                        end
                    end
                    else if (!frame_full)
                    begin
                        // Early fetch: answer not ready at once.
                        res_gray_next = mmg_pkg::GRAY_MIN;
                        res_last_next = 1'b0;
                        res_nr_next   = 1'b1;
                        state_next    = S_WAIT;
                    end
                    else
                    begin
                        res_last_next = fetch_last;
                        res_nr_next   = 1'b0;
                        state_next    = S_PREP;
                    end
                end
            end

            S_PREP:
            begin
                // Samples at or below the minimum, or at or above the
                // maximum, clamp without a division.
                if (v_e <= lo_sel)
                begin
                    res_gray_next = mmg_pkg::GRAY_MIN;
                    state_next    = S_WAIT;
                end
                else if (v_e >= hi_sel)
                begin
                    res_gray_next = mmg_pkg::GRAY_MAX;
                    state_next    = S_WAIT;
                end
                else
                begin
                    state_next = S_DIV;
                end
                // Min and max have been used, so the frame may rearm now.
                if (res_last_reg)
                begin
                    loaded_next = '0;
                    rdpos_next  = '0;
                    min_next    = SAMPLE_POS_MAX;
                    max_next    = SAMPLE_NEG_MAX;
                end
                else
                begin
                    rdpos_next = rdpos_reg + ADDR_W'(1);
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_gray_next = div_quot;
                    state_next    = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            rdpos_reg     <= '0;
            min_reg       <= SAMPLE_POS_MAX;
            max_reg       <= SAMPLE_NEG_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            rdpos_reg     <= rdpos_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result staging and output payload; the payload only moves when a
    // new result is handed over, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        res_gray_reg <= res_gray_next;
        res_last_reg <= res_last_next;
        res_nr_reg   <= res_nr_next;
        if ((state_reg == S_WAIT) && out_free)
        begin
            gray_reg <= res_gray_reg;
            last_reg <= res_last_reg;
            nr_reg   <= res_nr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gray       = gray_reg;
    assign last_pixel = last_reg;
    assign not_ready  = nr_reg;

endmodule : minmax_normalize_to_gray
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the min-max gray normaliser
// Drives load and fetch requests with random gaps and output stalls, keeps
// its own copy of the frame, running extremes and read position, and checks
// every gray result against that copy or a typed-in answer. A short table of
// hand-picked requests leads, then random frames of assorted sizes and spreads.
// ----------------------------------------------------------------------------
module tb;

    localparam int SB              = mmg_pkg::SAMPLE_BITS_DEF;
    localparam int RANDOM_ITEMS    = 600;   // counted requests in the random part
    localparam int CALM_TAIL       = 120;   // final requests run without idling
    localparam int SETTLE_CYCLES   = 16;    // settling wait after the last result
    localparam int HOLD_OFF_CYCLES = 80;    // long receiver hold-off
    localparam int QUIET_LIMIT     = 1000;  // watchdog: cycles with no transfer

    // One gray result as it leaves the block.
    typedef struct packed {
        logic [mmg_pkg::GRAY_W-1:0] gray;
        logic                       last_pixel;
        logic                       not_ready;
    } gray_result_t;

    // Kinds of row in the directed table; a size row writes pixel_count.
    typedef enum logic [1:0] {ROW_LOAD, ROW_FETCH, ROW_SIZE} stim_row_kind_t;

    typedef struct {
        stim_row_kind_t kind;
        logic [15:0]    value;    // sample for a load, register value for a size row
        bit             pinned;   // answer typed in rather than predicted
        gray_result_t   answer;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block connections. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic                          req_type  = mmg_pkg::REQ_LOAD;
    logic signed [SB-1:0]          sample    = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [mmg_pkg::GRAY_W-1:0]    gray;
    logic                          last_pixel;
    logic                          not_ready;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [mmg_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [mmg_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [mmg_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    always #10 clk = ~clk;

    minmax_normalize_to_gray dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .gray       (gray),
        .last_pixel (last_pixel),
        .not_ready  (not_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the block. It is advanced at the clock edge where a
    // request is accepted, so it always reflects what the block has been told.
    // ------------------------------------------------------------------------
    logic signed [SB-1:0]                pix_copy [mmg_pkg::MAX_PIXELS_DEF];
    logic [mmg_pkg::PIXEL_COUNT_W-1:0]   size_reg_copy = mmg_pkg::PIXEL_COUNT_RESET;
    int                                  loaded_n      = 0;
    int                                  fetch_pos     = 0;
    int                                  lo_seen       = (1 << (SB - 1)) - 1;
    int                                  hi_seen       = -(1 << (SB - 1));

    gray_result_t gray_expected_q [$];

    // A directed row with a typed-in answer hands it over through these two.
    bit           pinned_pending = 1'b0;
    gray_result_t pinned_result;

    bit idle_en      = 1'b1;  // random gaps and stalls on both channels
    bit hold_off_req = 1'b0;  // asks the result sink for one long hold-off
    int errors       = 0;

    // Statistics for the closing summary.
    int n_loads = 0, n_ignored = 0, n_fetches = 0, n_early = 0;
    int n_frames = 0, n_flat = 0, n_checked = 0;

    // Clear the counters and extremes once a frame has been read out.
    function automatic void restart_frame();
        loaded_n  = 0;
        fetch_pos = 0;
        lo_seen   = (1 << (SB - 1)) - 1;
        hi_seen   = -(1 << (SB - 1));
    endfunction

    // Stretch one sample to gray. A flat frame (no spread between the extremes)
    // falls back to the window 0 .. 1.0, which is then stretched as usual.
    function automatic logic [mmg_pkg::GRAY_W-1:0] gray_of(input int v);
        int     lo;
        int     hi;
        longint q;
        lo = lo_seen;
        hi = hi_seen;
        if (hi <= lo)
        begin
            lo = 0;
            hi = 1 << mmg_pkg::FRAC_BITS;
        end
        if (v <= lo)
            return mmg_pkg::GRAY_MIN;
        if (v >= hi)
            return mmg_pkg::GRAY_MAX;
        q = (longint'(v - lo) * longint'(mmg_pkg::GRAY_MAX)) / longint'(hi - lo);
        if (q > longint'(mmg_pkg::GRAY_MAX))
            q = longint'(mmg_pkg::GRAY_MAX);
        return q[mmg_pkg::GRAY_W-1:0];
    endfunction

    // Apply one accepted request to the shadow state. Returns 1 when the
    // request produces a result, which is then placed in res.
    function automatic bit normalise_request(input logic rt,
                                             input logic signed [SB-1:0] s,
                                             output gray_result_t res);
        int size;
        int v;
        bit full;
        size = (size_reg_copy == 0) ? 1 : int'(size_reg_copy);
        if (size > mmg_pkg::MAX_PIXELS_DEF)
            size = mmg_pkg::MAX_PIXELS_DEF;
        full = (loaded_n >= size);
        res  = '0;
        if (rt == mmg_pkg::REQ_LOAD)
        begin
            // Loads into a full frame, readout included, are dropped.
            if (full)
                return 1'b0;
            v = s;
            pix_copy[loaded_n] = s;
            if (v < lo_seen)
                lo_seen = v;
            if (v > hi_seen)
                hi_seen = v;
            loaded_n++;
            return 1'b0;
        end
        // A fetch before the frame is full answers not ready and changes nothing.
        if (!full)
        begin
            res.not_ready = 1'b1;
            return 1'b1;
        end
        if (hi_seen <= lo_seen)
            n_flat++;
        res.gray       = gray_of(pix_copy[fetch_pos]);
        res.last_pixel = (fetch_pos + 1 >= size);
        if (res.last_pixel)
            restart_frame();
        else
            fetch_pos++;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Request monitor: predicts the result of every accepted request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : request_monitor
        gray_result_t predicted;
        bit           answers;
        int           loaded_before;
        if (rst_n && in_valid && !in_stall)
        begin
            loaded_before = loaded_n;
            answers = normalise_request(req_type, sample, predicted);
            if (req_type == mmg_pkg::REQ_LOAD)
            begin
                n_loads++;
                if (loaded_n == loaded_before)
                    n_ignored++;
            end
            else
            begin
                n_fetches++;
                if (predicted.not_ready)
                    n_early++;
                if (predicted.last_pixel)
                    n_frames++;
            end
            if (answers)
            begin
                if (pinned_pending)
                begin
                    gray_expected_q.push_back(pinned_result);
                    pinned_pending = 1'b0;
                end
                else
                    gray_expected_q.push_back(predicted);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compares every accepted result with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_checker
        gray_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (gray_expected_q.size() == 0)
            begin
                $display("%0t: unexpected result gray=%0d last_pixel=%0b not_ready=%0b",
                         $time, gray, last_pixel, not_ready);
                errors++;
            end
            else
            begin
                want = gray_expected_q.pop_front();
                n_checked++;
                if (gray !== want.gray)
                begin
                    $display("%0t: gray mismatch, expected %0d, got %0d",
                             $time, want.gray, gray);
                    errors++;
                end
                if (last_pixel !== want.last_pixel)
                begin
                    $display("%0t: last_pixel mismatch, expected %0b, got %0b",
                             $time, want.last_pixel, last_pixel);
                    errors++;
                end
                if (not_ready !== want.not_ready)
                begin
                    $display("%0t: not_ready mismatch, expected %0b, got %0b",
                             $time, want.not_ready, not_ready);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no transfer on any port means a hang.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Result sink: stalls in short random bursts, and once holds off for a
    // long stretch so that the block backs up and stalls its request side.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. Each call starts at a falling edge and returns at the
    // falling edge after acceptance, leaving valid high so that back-to-back
    // requests need no second assignment in the same step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic rt, input logic signed [SB-1:0] s);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Stop offering requests, wait for every outstanding result, then give a
    // load or a clamped fetch still inside the block time to finish.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (gray_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write pixel_count through the configuration port: setup then access.
    task automatic write_pixel_count(input logic [mmg_pkg::PIXEL_COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mmg_pkg::PADDR_W'(4 * int'(mmg_pkg::REG_PIXEL_COUNT));
        pwdata  <= mmg_pkg::PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        size_reg_copy = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [$];

    task automatic add_row(input stim_row_kind_t kind, input logic [15:0] value,
                           input bit pinned = 1'b0,
                           input logic [mmg_pkg::GRAY_W-1:0] g = '0,
                           input logic l = 1'b0, input logic nr = 1'b0);
        stim_row_t r;
        r.kind   = kind;
        r.value  = value;
        r.pinned = pinned;
        r.answer = '{gray: g, last_pixel: l, not_ready: nr};
        directed_rows.push_back(r);
    endtask

    // Random samples for one frame, shaped by a spread style:
    // 0 spans the whole range, 1 sits in a narrow window, 2 is a flat frame,
    // 3 is mostly one value with the odd extreme thrown in.
    function automatic logic signed [SB-1:0] draw_sample(input int style,
                                                         input logic signed [SB-1:0] base,
                                                         input int span);
        case (style)
            0: return SB'($urandom);
            1: return base + SB'($urandom_range(0, span));
            2: return base;
            default:
                if ($urandom_range(0, 5) == 0)
                    return ($urandom_range(0, 1) == 0) ? {1'b1, {(SB-1){1'b0}}}
                                                       : {1'b0, {(SB-1){1'b1}}};
                else
                    return base;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int                                counted;
        int                                frame_no;
        int                                pick;
        int                                eff;
        int                                style;
        int                                span;
        bit                                pressure_done;
        logic [mmg_pkg::PIXEL_COUNT_W-1:0] gen_size;
        logic signed [SB-1:0]              base;

        counted       = 0;
        frame_no      = 0;
        pressure_done = 1'b0;

        // Empty frame at the reset size, then the smallest frames: the most
        // positive and most negative samples, each a flat frame of its own,
        // and a size of zero which behaves as one.
        add_row(ROW_SIZE,  16'd16384);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b0, 1'b1);
        add_row(ROW_SIZE,  16'd1);
        add_row(ROW_LOAD,  16'h7FFF);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MAX, 1'b1, 1'b0);
        add_row(ROW_SIZE,  16'd0);
        add_row(ROW_LOAD,  16'h8000);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b1, 1'b0);
        add_row(ROW_LOAD,  16'h0080);          // 0.5 in a flat frame
        add_row(ROW_FETCH, 16'h0000);
        // Three pixels over the full range, with an early fetch part-way
        // through loading and a load that arrives once the frame is full.
        add_row(ROW_SIZE,  16'd3);
        add_row(ROW_LOAD,  16'h8000);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b0, 1'b1);
        add_row(ROW_LOAD,  16'h7FFF);
        add_row(ROW_LOAD,  16'h0001);
        add_row(ROW_LOAD,  16'h1234);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b0, 1'b0);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MAX, 1'b0, 1'b0);
        add_row(ROW_FETCH, 16'h0000);
        // A size beyond the store acts as the store size; shrinking it
        // mid-frame below the number loaded makes the frame full at once.
        add_row(ROW_SIZE,  16'd32767);
        add_row(ROW_LOAD,  16'h0064);
        add_row(ROW_LOAD,  16'hFF9C);
        add_row(ROW_LOAD,  16'h0032);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b0, 1'b1);
        add_row(ROW_SIZE,  16'd2);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MAX, 1'b0, 1'b0);
        add_row(ROW_FETCH, 16'h0000, 1'b1, mmg_pkg::GRAY_MIN, 1'b1, 1'b0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_SIZE:
                begin
                    settle_block();
                    write_pixel_count(directed_rows[i].value[mmg_pkg::PIXEL_COUNT_W-1:0]);
                end
                ROW_LOAD:
                    send_request(mmg_pkg::REQ_LOAD, directed_rows[i].value);
                default:
                begin
                    if (directed_rows[i].pinned)
                    begin
                        pinned_result  = directed_rows[i].answer;
                        pinned_pending = 1'b1;
                    end
                    send_request(mmg_pkg::REQ_FETCH, directed_rows[i].value);
                end
            endcase
        end
        settle_block();
        gen_size = size_reg_copy;

        // Random frames: mostly well-formed load-then-read sequences, with
        // early fetches and surplus loads mixed in as noise.
        while (counted < RANDOM_ITEMS)
        begin
            frame_no++;
            pick = $urandom_range(0, 99);
            if (!pressure_done && frame_no == 6)
                gen_size = mmg_pkg::PIXEL_COUNT_W'(24);
            else if ($urandom_range(0, 3) != 0)
            begin
                if (pick < 8)
                    gen_size = '0;
                else if (pick < 85)
                    gen_size = mmg_pkg::PIXEL_COUNT_W'($urandom_range(1, 12));
                else
                    gen_size = mmg_pkg::PIXEL_COUNT_W'($urandom_range(13, 40));
            end
            if (gen_size != size_reg_copy)
                write_pixel_count(gen_size);
            eff   = (gen_size == 0) ? 1 : int'(gen_size);
            style = $urandom_range(0, 3);
            span  = $urandom_range(1, 2000);
            if (style == 2 && $urandom_range(0, 1) == 0)
                base = SB'(int'($urandom_range(0, 384)) - 64);   // around 0 .. 1.0
            else
                base = SB'($urandom);

            for (int k = 0; k < eff; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_request(mmg_pkg::REQ_FETCH, SB'($urandom));
                    counted++;
                end
                send_request(mmg_pkg::REQ_LOAD, draw_sample(style, base, span));
                counted++;
            end
            if ($urandom_range(0, 5) == 0)
                send_request(mmg_pkg::REQ_LOAD, SB'($urandom));

            // Once in the run the sink holds off while fetches keep coming.
            if (!pressure_done && frame_no == 6)
            begin
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
            end

            for (int k = 0; k < eff; k++)
            begin
                if (k != 0 && $urandom_range(0, 9) == 0)
                    send_request(mmg_pkg::REQ_LOAD, SB'($urandom));
                send_request(mmg_pkg::REQ_FETCH, SB'($urandom));
                counted++;
            end

            if (counted >= RANDOM_ITEMS - CALM_TAIL)
                idle_en = 1'b0;
            settle_block();
        end

        $display("Covered %0d loads (%0d dropped into a full frame) and %0d fetches",
                 n_loads, n_ignored, n_fetches);
        $display("%0d early fetches, %0d frames read out, %0d flat-frame pixels, %0d results",
                 n_early, n_frames, n_flat, n_checked);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: minmax_normalize_to_gray.f
rtl/mmg_pkg.sv
rtl/mmg_cfg_regs.sv
rtl/mmg_frame_store.sv
rtl/mmg_serial_div.sv
rtl/minmax_normalize_to_gray.sv
tb/tb.sv
